// ===== rtl/ppt_pkg.sv =====
// ----------------------------------------------------------------------------
// Pedal plausibility package
// Shared constants and the configuration register index codes.
// ----------------------------------------------------------------------------
package ppt_pkg;

  localparam int unsigned SAMPLE_BITS = 12;
  localparam int unsigned QBITS = 16;
  localparam int unsigned PBITS = SAMPLE_BITS + 7;
  localparam logic [16:0] Q_ONE = 17'h10000;

  typedef enum logic [2:0] {
    REG_APPS1_MIN  = 3'd0,
    REG_APPS1_MAX  = 3'd1,
    REG_APPS2_MIN  = 3'd2,
    REG_APPS2_MAX  = 3'd3,
    REG_BRAKE_MIN  = 3'd4,
    REG_BRAKE_MAX  = 3'd5,
    REG_BRAKE_ON   = 3'd6,
    REG_FAULT_DLY  = 3'd7
  } reg_idx_t;

  localparam logic OP_SAMPLE = 1'b0;
  localparam logic OP_TICK   = 1'b1;

endpackage

// ===== rtl/pedal_plausibility_throttle_map.sv =====
// ----------------------------------------------------------------------------
// Pedal plausibility and throttle map
// Converts two accelerator samples to a DAC code and checks sensor faults.
// ----------------------------------------------------------------------------
// Each sample's two accelerator fractions run one after the other through one
// shared bit-serial divider (which finishes early when the fraction saturates at
// one), followed by a map state and a flag state. A tick's result is registered
// in the tick state before it is presented. The block takes no new item until
// its result has been transferred out.
module pedal_plausibility_throttle_map
  import ppt_pkg::*;
#(
  parameter int unsigned WATCHDOG_TICKS = 1000
) (
  input  logic                   clk,
  input  logic                   rst_n,
  input  logic                   in_valid,
  output logic                   in_stall,
  input  logic                   in_opcode,
  input  logic [SAMPLE_BITS-1:0] in_apps1_raw,
  input  logic [SAMPLE_BITS-1:0] in_apps2_raw,
  input  logic [SAMPLE_BITS-1:0] in_brake_raw,
  output logic                   out_valid,
  input  logic                   out_stall,
  output logic [8:0]             out_throttle_code,
  output logic                   out_apps1_range_fault,
  output logic                   out_apps2_range_fault,
  output logic                   out_brake_range_fault,
  output logic                   out_apps_disagree_fault,
  output logic                   out_brake_plausibility_fault,
  output logic                   out_watchdog_off,
  input  logic                   cfg_valid,
  output logic                   cfg_ready,
  input  logic [2:0]             cfg_index,
  input  logic [15:0]            cfg_data
);

  localparam int unsigned WDW = $clog2(WATCHDOG_TICKS + 1);

  typedef enum logic [2:0] {
    S_IDLE, S_DIV1, S_DIV2, S_MAP, S_FLAGS, S_TICK, S_OUT
  } state_t;

  state_t state_r;

  logic [11:0] a1min_r, a1max_r, a2min_r, a2max_r, bmin_r, bmax_r, bon_r;
  logic [15:0] delay_r;
  logic [SAMPLE_BITS-1:0] a1_r, a2_r, br_r;
  logic [16:0] f1_r, f2_r;
  logic [8:0]  held_r;
  logic [3:0]  cond_r, flags_r;
  logic [15:0] cnt_r [4];
  logic        latch_r;
  logic [WDW-1:0] wd_r;

  logic [SAMPLE_BITS-1:0] m1min, m1max, m2min, m2max, mbmin, mbmax, mbon;
  assign m1min = SAMPLE_BITS'(a1min_r);
  assign m1max = SAMPLE_BITS'(a1max_r);
  assign m2min = SAMPLE_BITS'(a2min_r);
  assign m2max = SAMPLE_BITS'(a2max_r);
  assign mbmin = SAMPLE_BITS'(bmin_r);
  assign mbmax = SAMPLE_BITS'(bmax_r);
  assign mbon  = SAMPLE_BITS'(bon_r);

  // Shared pad/compare front end for whichever sensor is in the divider.
  logic             sel2;
  logic [SAMPLE_BITS-1:0] fr, flo, fhi;
  logic [PBITS-1:0] r100, pl, ph;
  logic             below, above, degen;
  logic             dv_start, dv_done;
  logic [16:0]      dv_q;
  logic             cnt_pend_r;

  assign sel2 = (state_r == S_DIV2);
  assign fr   = sel2 ? a2_r : a1_r;
  assign flo  = sel2 ? m2min : m1min;
  assign fhi  = sel2 ? m2max : m1max;
  assign r100 = PBITS'(fr) * PBITS'(100);
  assign pl   = PBITS'(flo) * PBITS'(108);
  assign ph   = PBITS'(fhi) * PBITS'(92);
  assign below = r100 < pl;
  assign above = r100 > ph;
  assign degen = ph == pl;

  assign dv_start = cnt_pend_r;

  ppt_frac_div u_div (
    .clk   (clk),
    .rst_n (rst_n),
    .start (dv_start),
    .num   (r100 - pl),
    .den   (ph - pl),
    .done  (dv_done),
    .quot  (dv_q)
  );

  logic [17:0] fsum;
  logic [26:0] prod;
  logic [16:0] diff;
  logic [20:0] diff10;
  logic [3:0]  cond;
  logic [15:0] dly;

  assign fsum   = {1'b0, f1_r} + {1'b0, f2_r};
  assign prod   = 27'(fsum) * 27'd390;
  assign diff   = (f1_r > f2_r) ? f1_r - f2_r : f2_r - f1_r;
  assign diff10 = 21'(diff) * 21'd10;
  assign dly    = (delay_r == 16'd0) ? 16'd1 : delay_r;

  always_comb begin
    cond[0] = (a1_r < m1min) || (a1_r > m1max);
    cond[1] = (a2_r < m2min) || (a2_r > m2max);
    cond[2] = (br_r < mbmin) || (br_r > mbmax);
    cond[3] = diff10 > 21'(Q_ONE);
  end

  assign in_stall  = (state_r != S_IDLE);
  assign cfg_ready = (state_r == S_IDLE);
  assign out_valid = (state_r == S_OUT);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r    <= S_IDLE;
      a1min_r    <= 12'd0;
      a1max_r    <= 12'd4095;
      a2min_r    <= 12'd0;
      a2max_r    <= 12'd4095;
      bmin_r     <= 12'd0;
      bmax_r     <= 12'd4095;
      bon_r      <= 12'd2048;
      delay_r    <= 16'd100;
      held_r     <= '0;
      cond_r     <= '0;
      flags_r    <= '0;
      latch_r    <= 1'b0;
      wd_r       <= '0;
      cnt_pend_r <= 1'b0;
      for (int i = 0; i < 4; i++) cnt_r[i] <= '0;
    end else begin
      cnt_pend_r <= 1'b0;
      if (cfg_valid && cfg_ready) begin
        unique case (reg_idx_t'(cfg_index))
          REG_APPS1_MIN: a1min_r <= cfg_data[11:0];
          REG_APPS1_MAX: a1max_r <= cfg_data[11:0];
          REG_APPS2_MIN: a2min_r <= cfg_data[11:0];
          REG_APPS2_MAX: a2max_r <= cfg_data[11:0];
          REG_BRAKE_MIN: bmin_r  <= cfg_data[11:0];
          REG_BRAKE_MAX: bmax_r  <= cfg_data[11:0];
          REG_BRAKE_ON:  bon_r   <= cfg_data[11:0];
          REG_FAULT_DLY: delay_r <= cfg_data;
          default: ;
        endcase
      end
      unique case (state_r)
        S_IDLE: begin
          if (in_valid) begin
            a1_r <= in_apps1_raw;
            a2_r <= in_apps2_raw;
            br_r <= in_brake_raw;
            if (in_opcode == OP_TICK) begin
              state_r <= S_TICK;
            end else begin
              state_r    <= S_DIV1;
              cnt_pend_r <= 1'b1;
            end
          end
        end
        S_DIV1, S_DIV2: begin
          if (dv_done) begin
            if (sel2) begin
              f2_r    <= below ? 17'd0 : above ? Q_ONE : degen ? 17'd0 : dv_q;
              state_r <= S_MAP;
            end else begin
              f1_r       <= below ? 17'd0 : above ? Q_ONE : degen ? 17'd0 : dv_q;
              state_r    <= S_DIV2;
              cnt_pend_r <= 1'b1;
            end
          end
        end
        S_MAP: begin
          held_r  <= 9'(prod[26:17]) + 9'd60;
          state_r <= S_FLAGS;
        end
        S_FLAGS: begin
          for (int i = 0; i < 4; i++) begin
            if (!cond[i]) begin
              cnt_r[i]   <= '0;
              flags_r[i] <= 1'b0;
            end
          end
          cond_r <= cond;
          if (br_r >= mbon && f1_r >= 17'h04000 && f2_r >= 17'h04000) begin
            latch_r <= 1'b1;
          end else if (21'(f1_r) * 21'd20 < 21'(Q_ONE) &&
                       21'(f2_r) * 21'd20 < 21'(Q_ONE)) begin
            latch_r <= 1'b0;
          end
          wd_r    <= '0;
          state_r <= S_OUT;
        end
        S_TICK: begin
          for (int i = 0; i < 4; i++) begin
            if (cond_r[i]) begin
              if (cnt_r[i] != 16'hFFFF) cnt_r[i] <= cnt_r[i] + 16'd1;
              if ((cnt_r[i] != 16'hFFFF ? cnt_r[i] + 16'd1 : cnt_r[i]) >= dly)
                flags_r[i] <= 1'b1;
            end
          end
          if (wd_r < WDW'(WATCHDOG_TICKS)) begin
            wd_r <= wd_r + WDW'(1);
            if (wd_r + WDW'(1) >= WDW'(WATCHDOG_TICKS)) held_r <= '0;
          end
          state_r <= S_OUT;
        end
        S_OUT: begin
          if (!out_stall) state_r <= S_IDLE;
        end
        default: state_r <= S_IDLE;
      endcase
    end
  end

  logic wd_off;
  assign wd_off = wd_r >= WDW'(WATCHDOG_TICKS);

  assign out_throttle_code            = wd_off ? 9'd0 : held_r;
  assign out_apps1_range_fault        = flags_r[0];
  assign out_apps2_range_fault        = flags_r[1];
  assign out_brake_range_fault        = flags_r[2];
  assign out_apps_disagree_fault      = flags_r[3];
  assign out_brake_plausibility_fault = latch_r;
  assign out_watchdog_off             = wd_off;

  a_no_flag_without_cond: assert property (@(posedge clk) disable iff (!rst_n)
    state_r == S_OUT |-> (flags_r & ~cond_r) == 4'd0)
    else $error("fault flag set without its condition");
  a_wd_bound: assert property (@(posedge clk) disable iff (!rst_n)
    wd_r <= WDW'(WATCHDOG_TICKS))
    else $error("watchdog count overran");
  a_cfg_idle: assert property (@(posedge clk) disable iff (!rst_n)
    cfg_ready |-> !out_valid)
    else $error("configuration accepted while busy");

endmodule

// ===== rtl/ppt_frac_div.sv =====
// ----------------------------------------------------------------------------
// Pedal fraction divider
// Restoring divider that produces one quotient bit per cycle for the Q16
// pedal fraction of a sample against its padded bounds.
// ----------------------------------------------------------------------------
module ppt_frac_div
  import ppt_pkg::*;
(
  input  logic             clk,
  input  logic             rst_n,
  input  logic             start,
  input  logic [PBITS-1:0] num,
  input  logic [PBITS-1:0] den,
  output logic             done,
  output logic [16:0]      quot
);

  logic [4:0]       cnt_r, cnt_nxt;
  logic             busy_r, busy_nxt;
  logic [PBITS:0]   rem_r, rem_nxt;
  logic [16:0]      q_r, q_nxt;
  logic [PBITS-1:0] den_r, den_nxt;
  logic             done_r, done_nxt;
  logic [PBITS+1:0] trial;

  always_comb begin
    cnt_nxt  = cnt_r;
    busy_nxt = busy_r;
    rem_nxt  = rem_r;
    q_nxt    = q_r;
    den_nxt  = den_r;
    done_nxt = 1'b0;
    trial    = '0;
    if (start) begin
      busy_nxt = 1'b1;
      cnt_nxt  = 5'd0;
      rem_nxt  = {1'b0, num};
      q_nxt    = '0;
      den_nxt  = den;
    end else if (busy_r) begin
      trial = {rem_r, 1'b0} - {2'b00, den_r};
      if (cnt_r == 5'd0) begin
        if (rem_r >= {1'b0, den_r}) begin
          q_nxt   = Q_ONE;
          busy_nxt = 1'b0;
          done_nxt = 1'b1;
        end else begin
          cnt_nxt = 5'd1;
        end
      end else begin
        if (!trial[PBITS+1]) begin
          rem_nxt = trial[PBITS:0];
          q_nxt   = {q_r[15:0], 1'b1};
        end else begin
          rem_nxt = {rem_r[PBITS-1:0], 1'b0};
          q_nxt   = {q_r[15:0], 1'b0};
        end
        cnt_nxt = cnt_r + 5'd1;
        if (cnt_r == 5'd16) begin
          busy_nxt = 1'b0;
          done_nxt = 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
      cnt_r  <= '0;
    end else begin
      busy_r <= busy_nxt;
      done_r <= done_nxt;
      cnt_r  <= cnt_nxt;
    end
    rem_r <= rem_nxt;
    q_r   <= q_nxt;
    den_r <= den_nxt;
  end

  assign done = done_r;
  assign quot = q_r;

endmodule

// ===== tb/tb_top.sv =====
// ----------------------------------------------------------------------------
// Pedal plausibility and throttle map testbench
// Drives samples and ticks through several idle phases and register settings.
// A scoreboard class predicts every result and checks it field by field.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module tb_top
  import ppt_pkg::*;
;

  typedef struct packed {
    logic [8:0] throttle;
    logic       a1_flt;
    logic       a2_flt;
    logic       br_flt;
    logic       dis_flt;
    logic       plaus;
    logic       wd_off;
  } pedal_result_t;

  class pedal_scoreboard;
    logic [11:0] lim_lo[3];
    logic [11:0] lim_hi[3];
    logic [11:0] brake_on;
    logic [15:0] delay_ticks;
    logic [8:0]  held;
    logic [3:0]  cond;
    logic [15:0] cnt[4];
    logic [3:0]  flags;
    logic        latch;
    int unsigned wd_cnt;
    pedal_result_t pending[$];
    int errors;

    function new();
      lim_lo = '{12'd0, 12'd0, 12'd0};
      lim_hi = '{12'd4095, 12'd4095, 12'd4095};
      brake_on = 12'd2048;
      delay_ticks = 16'd100;
      held = '0;
      cond = '0;
      cnt = '{16'd0, 16'd0, 16'd0, 16'd0};
      flags = '0;
      latch = 1'b0;
      wd_cnt = 0;
      errors = 0;
    endfunction

    function void write_reg(reg_idx_t idx, logic [15:0] val);
      case (idx)
        REG_APPS1_MIN: lim_lo[0] = val[11:0];
        REG_APPS1_MAX: lim_hi[0] = val[11:0];
        REG_APPS2_MIN: lim_lo[1] = val[11:0];
        REG_APPS2_MAX: lim_hi[1] = val[11:0];
        REG_BRAKE_MIN: lim_lo[2] = val[11:0];
        REG_BRAKE_MAX: lim_hi[2] = val[11:0];
        REG_BRAKE_ON:  brake_on = val[11:0];
        REG_FAULT_DLY: delay_ticks = val;
        default: ;
      endcase
    endfunction

    function longint unsigned fraction(logic [11:0] raw, logic [11:0] lo, logic [11:0] hi);
      longint unsigned r, pl, ph, q;
      r = 100 * raw;
      pl = 108 * lo;
      ph = 92 * hi;
      if (r < pl) return 0;
      if (r > ph) return 65536;
      if (ph == pl) return 0;
      q = ((r - pl) * 65536) / (ph - pl);
      return (q > 65536) ? 65536 : q;
    endfunction

    function void note_input(logic op, logic [11:0] a1, logic [11:0] a2, logic [11:0] br);
      longint unsigned f1, f2, diff;
      int unsigned dly;
      pedal_result_t res;
      if (op == OP_SAMPLE) begin
        f1 = fraction(a1, lim_lo[0], lim_hi[0]);
        f2 = fraction(a2, lim_lo[1], lim_hi[1]);
        diff = (f1 > f2) ? f1 - f2 : f2 - f1;
        held = 9'((390 * (f1 + f2)) / 131072 + 60);
        cond[0] = (a1 < lim_lo[0]) || (a1 > lim_hi[0]);
        cond[1] = (a2 < lim_lo[1]) || (a2 > lim_hi[1]);
        cond[2] = (br < lim_lo[2]) || (br > lim_hi[2]);
        cond[3] = (10 * diff > 65536);
        for (int i = 0; i < 4; i++) begin
          if (!cond[i]) begin
            cnt[i] = '0;
            flags[i] = 1'b0;
          end
        end
        if (br >= brake_on && f1 >= 16384 && f2 >= 16384) begin
          latch = 1'b1;
        end else if (20 * f1 < 65536 && 20 * f2 < 65536) begin
          latch = 1'b0;
        end
        wd_cnt = 0;
      end else begin
        dly = (delay_ticks == 0) ? 1 : delay_ticks;
        for (int i = 0; i < 4; i++) begin
          if (cond[i]) begin
            if (cnt[i] != 16'hFFFF) cnt[i] = cnt[i] + 1;
            if (cnt[i] >= dly) flags[i] = 1'b1;
          end
        end
        if (wd_cnt < 1000) begin
          wd_cnt++;
          if (wd_cnt >= 1000) held = '0;
        end
      end
      res.wd_off = (wd_cnt >= 1000);
      res.throttle = res.wd_off ? 9'd0 : held;
      res.a1_flt = flags[0];
      res.a2_flt = flags[1];
      res.br_flt = flags[2];
      res.dis_flt = flags[3];
      res.plaus = latch;
      pending.push_back(res);
    endfunction

    function void check_result(pedal_result_t got);
      pedal_result_t exp_r;
      if (pending.size() == 0) begin
        $display("%0t: unexpected result %p", $realtime, got);
        errors++;
        return;
      end
      exp_r = pending.pop_front();
      if (got.throttle !== exp_r.throttle)
        $display("%0t: throttle exp %0d got %0d", $realtime, exp_r.throttle, got.throttle);
      if (got.a1_flt !== exp_r.a1_flt)
        $display("%0t: apps1 fault exp %b got %b", $realtime, exp_r.a1_flt, got.a1_flt);
      if (got.a2_flt !== exp_r.a2_flt)
        $display("%0t: apps2 fault exp %b got %b", $realtime, exp_r.a2_flt, got.a2_flt);
      if (got.br_flt !== exp_r.br_flt)
        $display("%0t: brake fault exp %b got %b", $realtime, exp_r.br_flt, got.br_flt);
      if (got.dis_flt !== exp_r.dis_flt)
        $display("%0t: disagree exp %b got %b", $realtime, exp_r.dis_flt, got.dis_flt);
      if (got.plaus !== exp_r.plaus)
        $display("%0t: plausibility exp %b got %b", $realtime, exp_r.plaus, got.plaus);
      if (got.wd_off !== exp_r.wd_off)
        $display("%0t: watchdog exp %b got %b", $realtime, exp_r.wd_off, got.wd_off);
      if (got !== exp_r) errors++;
    endfunction
  endclass

  logic        clk = 1'b0;
  logic        rst_n = 1'b0;
  logic        in_valid = 1'b0;
  logic        in_stall;
  logic        in_opcode = 1'b0;
  logic [11:0] in_apps1_raw = '0;
  logic [11:0] in_apps2_raw = '0;
  logic [11:0] in_brake_raw = '0;
  logic        out_valid;
  logic        out_stall = 1'b0;
  logic [8:0]  out_throttle_code;
  logic        out_apps1_range_fault;
  logic        out_apps2_range_fault;
  logic        out_brake_range_fault;
  logic        out_apps_disagree_fault;
  logic        out_brake_plausibility_fault;
  logic        out_watchdog_off;
  logic        cfg_valid = 1'b0;
  logic        cfg_ready;
  logic [2:0]  cfg_index = '0;
  logic [15:0] cfg_data = '0;

  int send_idle_pct = 0;
  int recv_stall_pct = 0;
  pedal_scoreboard throttle_sb = new();

  always #5 clk = ~clk;

  pedal_plausibility_throttle_map i_dut (.*);

  always @(posedge clk) begin
    if (rst_n && out_valid && !out_stall) begin
      throttle_sb.check_result({out_throttle_code, out_apps1_range_fault,
                                out_apps2_range_fault, out_brake_range_fault,
                                out_apps_disagree_fault, out_brake_plausibility_fault,
                                out_watchdog_off});
    end
    out_stall <= ($urandom_range(99) < recv_stall_pct);
  end

  task automatic send_item(logic op, logic [11:0] a1, logic [11:0] a2, logic [11:0] br);
    while ($urandom_range(99) < send_idle_pct) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid <= 1'b1;
    in_opcode <= op;
    in_apps1_raw <= a1;
    in_apps2_raw <= a2;
    in_brake_raw <= br;
    do @(posedge clk); while (in_stall);
    throttle_sb.note_input(op, a1, a2, br);
  endtask

  task automatic wait_drained();
    in_valid <= 1'b0;
    cfg_valid <= 1'b0;
    while (throttle_sb.pending.size() != 0) @(posedge clk);
    repeat (50) @(posedge clk);
  endtask

  task automatic write_reg(reg_idx_t idx, logic [15:0] val);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data <= val;
    do @(posedge clk); while (!cfg_ready);
    throttle_sb.write_reg(idx, val);
  endtask

  task automatic set_limits(int a1l, int a1h, int a2l, int a2h, int bl, int bh, int bon,
                            int dly);
    write_reg(REG_APPS1_MIN, 16'(a1l));
    write_reg(REG_APPS1_MAX, 16'(a1h));
    write_reg(REG_APPS2_MIN, 16'(a2l));
    write_reg(REG_APPS2_MAX, 16'(a2h));
    write_reg(REG_BRAKE_MIN, 16'(bl));
    write_reg(REG_BRAKE_MAX, 16'(bh));
    write_reg(REG_BRAKE_ON, 16'(bon));
    write_reg(REG_FAULT_DLY, 16'(dly));
  endtask

  task automatic random_items(int n);
    logic [11:0] a1, a2;
    for (int k = 0; k < n; k++) begin
      if ($urandom_range(99) < 45) begin
        send_item(OP_TICK, 12'($urandom), 12'($urandom), 12'($urandom));
      end else begin
        a1 = 12'($urandom);
        a2 = ($urandom_range(1)) ? a1 + 12'($urandom_range(300)) - 12'd150 : 12'($urandom);
        send_item(OP_SAMPLE, a1, a2, 12'($urandom));
      end
    end
  endtask

  initial begin
    repeat (5) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    send_item(OP_SAMPLE, 12'd0, 12'd0, 12'd0);
    send_item(OP_SAMPLE, 12'd4095, 12'd4095, 12'd4095);
    send_item(OP_SAMPLE, 12'd4095, 12'd0, 12'd4095);
    send_item(OP_SAMPLE, 12'd2048, 12'd2048, 12'd2048);
    send_item(OP_SAMPLE, 12'd100, 12'd100, 12'd0);
    send_item(OP_SAMPLE, 12'd2048, 12'd2048, 12'd4095);
    send_item(OP_TICK, 12'd4095, 12'd4095, 12'd4095);
    wait_drained();
    set_limits(1000, 3000, 2000, 2000, 500, 3500, 4095, 0);
    wait_drained();
    send_item(OP_SAMPLE, 12'd999, 12'd2000, 12'd499);
    send_item(OP_TICK, 12'd0, 12'd0, 12'd0);
    send_item(OP_SAMPLE, 12'd3001, 12'd2160, 12'd3501);
    send_item(OP_TICK, 12'd0, 12'd0, 12'd0);
    send_item(OP_SAMPLE, 12'd2000, 12'd2160, 12'd4095);
    wait_drained();
    set_limits(4095, 100, 0, 4095, 4095, 0, 0, 3);
    wait_drained();
    send_item(OP_SAMPLE, 12'd4095, 12'd4095, 12'd0);
    send_item(OP_SAMPLE, 12'd10, 12'd10, 12'd4095);
    repeat (4) send_item(OP_TICK, 12'd0, 12'd0, 12'd0);
    wait_drained();
    set_limits(0, 4095, 0, 4095, 0, 4095, 2048, 1);
    wait_drained();
    send_item(OP_SAMPLE, 12'd2000, 12'd2000, 12'd100);
    repeat (1001) send_item(OP_TICK, 12'd0, 12'd0, 12'd0);
    send_item(OP_SAMPLE, 12'd3000, 12'd3000, 12'd3000);

    send_idle_pct = 69;
    random_items(30);
    wait_drained();
    set_limits(200, 3800, 300, 3700, 100, 4000, 1500, 5);
    wait_drained();
    send_idle_pct = 0;
    recv_stall_pct = 69;
    random_items(30);
    wait_drained();
    set_limits(0, 4095, 0, 4095, 0, 4095, 0, 65535);
    wait_drained();
    send_idle_pct = 35;
    recv_stall_pct = 35;
    random_items(30);
    wait_drained();
    set_limits($urandom_range(800), 4095 - $urandom_range(800), $urandom_range(800),
               4095 - $urandom_range(800), $urandom_range(800), 4095 - $urandom_range(800),
               $urandom_range(4095), $urandom_range(1, 20));
    wait_drained();
    send_idle_pct = 0;
    recv_stall_pct = 0;
    random_items(30);
    wait_drained();
    if (throttle_sb.errors == 0) begin
      $display("pedal_plausibility_throttle_map: match");
    end else begin
      $display("pedal_plausibility_throttle_map: mismatch");
    end
    $finish;
  end

  initial begin
    #20ms;
    $display("pedal_plausibility_throttle_map: mismatch");
    $finish;
  end

endmodule
